### hdl/orhc_pkg.sv
package orhc_pkg;

  // Widths of the fields on the ports.
  localparam int FIELD_BITS  = 16;
  localparam int ID_BITS     = 32;
  localparam int COST_BITS   = 27;
  localparam int WEIGHT_BITS = 11;
  localparam int SPREAD_BITS = 10;
  localparam int CFG_BITS    = 11;
  localparam int HASH_BITS   = 32;

  // Register indexes on the configuration port.
  localparam logic REG_WEIGHT = 1'b0;
  localparam logic REG_SPREAD = 1'b1;

  // Register limits and reset values.
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MIN   = 11'd256;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX   = 11'd1024;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 11'd294;
  localparam logic [SPREAD_BITS-1:0] SPREAD_MAX   = 10'd512;
  localparam logic [SPREAD_BITS-1:0] SPREAD_RESET = 10'd256;

  // Diagonal step factor sqrt(2) - 1 with 16 fraction bits.
  localparam logic [14:0] OCT_K_Q16 = 15'd27146;

  // Hash multipliers.
  localparam logic [HASH_BITS-1:0] HASH_C1 = 32'h9E37_79B1;
  localparam logic [HASH_BITS-1:0] HASH_C2 = 32'h85EB_CA6B;
  localparam logic [HASH_BITS-1:0] HASH_C3 = 32'h7FEB_352D;
  localparam logic [HASH_BITS-1:0] HASH_C4 = 32'h846C_A68B;

  // Noise product byte * spread fits 18 bits; dividing it by 255 is a
  // multiply by ceil(2^26 / 255) and a shift, exact over that range.
  localparam int NPROD_BITS  = 18;
  localparam int RECIP_BITS  = 19;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_BITS-1:0] RECIP_255 = 19'd263173;

  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

endpackage

### hdl/orhc_in_if.sv
interface orhc_in_if import orhc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ID_BITS-1:0]    search_id;
  logic [FIELD_BITS-1:0] goal_x_lo;
  logic [FIELD_BITS-1:0] goal_z_lo;
  logic [FIELD_BITS-1:0] goal_x_hi;
  logic [FIELD_BITS-1:0] goal_z_hi;
  logic [FIELD_BITS-1:0] cell_x;
  logic [FIELD_BITS-1:0] cell_z;

  modport source (
    output valid, search_id, goal_x_lo, goal_z_lo, goal_x_hi, goal_z_hi, cell_x, cell_z,
    input  ready
  );
  modport sink (
    input  valid, search_id, goal_x_lo, goal_z_lo, goal_x_hi, goal_z_hi, cell_x, cell_z,
    output ready
  );
endinterface

### hdl/orhc_out_if.sv
interface orhc_out_if import orhc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COST_BITS-1:0] cost_q8;

  modport source (output valid, cost_q8, input ready);
  modport sink (input valid, cost_q8, output ready);
endinterface

### hdl/octile_rect_heuristic_cost.sv
// Weighted octile-distance heuristic to a goal rectangle. Each query beat
// carries a search identity, a goal rectangle and a candidate cell; each
// answer beat carries cost_q8 = ((dmaj + 0.41421354 * dmin) * weight) plus,
// when the spread register is nonzero, a noise term (hash byte / 255) *
// spread, all unsigned with 8 fraction bits, truncated, and saturated at the
// 27-bit limit. The block is a six-stage pipeline: it takes one query beat
// per cycle while the answer side does not stall, and its answer comes from
// the stage 6 register. The depth is set by the hash, a chain of three 32-bit
// multiplies each followed by a register, followed by the byte-times-spread
// multiply and the reciprocal multiply that divides by 255. Every stage holds
// its own valid bit and loads whenever its downstream neighbor can take its
// contents, so a stall on the answer side backs up stage by stage, bubbles
// are squeezed out, and the query side keeps accepting until the pipeline is
// really full. The configuration port writes weight_q8 (index 0, clamped to
// 256..1024) and spread_q8 (index 1, low 10 bits clamped to 512); write it only
// while no query is in flight. Coordinates use their low COORD_BITS bits.
module octile_rect_heuristic_cost import orhc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wr_data,
  orhc_in_if.sink             query,
  orhc_out_if.source          answer
);

  // A per-axis distance reaches 2^COORD_BITS, so it needs one extra bit.
  localparam int D_BITS      = COORD_BITS + 1;
  // major * 2^16 + minor * K stays below 2^(COORD_BITS + 17).
  localparam int BASE_BITS   = COORD_BITS + 17;
  localparam int WPROD_BITS  = BASE_BITS + WEIGHT_BITS;
  localparam int SCALED_BITS = WPROD_BITS - 16;
  localparam int SUM_BITS    = SCALED_BITS + 1;
  localparam int WIDE_BITS   = (SUM_BITS > COST_BITS) ? SUM_BITS : COST_BITS;
  localparam int RPROD_BITS  = NPROD_BITS + RECIP_BITS;

  // Configuration registers. Out-of-range writes are clamped on the way in, spread after truncation to 10 bits.
  logic [WEIGHT_BITS-1:0] weight_q8;
  logic [SPREAD_BITS-1:0] spread_q8;
  logic [SPREAD_BITS-1:0] spread_wr;

  assign spread_wr = cfg_wr_data[SPREAD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_q8 <= WEIGHT_RESET;
      spread_q8 <= SPREAD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WEIGHT: begin
          if (cfg_wr_data < WEIGHT_MIN) begin
            weight_q8 <= WEIGHT_MIN;
          end else if (cfg_wr_data > WEIGHT_MAX) begin
            weight_q8 <= WEIGHT_MAX;
          end else begin
            weight_q8 <= cfg_wr_data;
          end
        end
        REG_SPREAD: begin
          spread_q8 <= (spread_wr > SPREAD_MAX) ? SPREAD_MAX : spread_wr;
        end
        default: begin
        end
      endcase
    end
  end

  // Distance from c to [lo, hi) on one axis: the largest of zero, lo - c and
  // c - hi + 1. With an inverted rectangle both terms can be positive.
  function automatic logic [D_BITS-1:0] axis_dist(
    input logic [COORD_BITS-1:0] lo,
    input logic [COORD_BITS-1:0] hi,
    input logic [COORD_BITS-1:0] c
  );
    logic [D_BITS-1:0] below;
    logic [D_BITS-1:0] above;
    below = (lo > c) ? ({1'b0, lo} - {1'b0, c}) : '0;
    above = (c >= hi) ? ({1'b0, c} - {1'b0, hi} + D_BITS'(1)) : '0;
    return (below > above) ? below : above;
  endfunction

  // Stage valid bits and the ready chain. A stage loads when it is empty or
  // its contents move on in the same cycle.
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6 || answer.ready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign query.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= query.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // Stage 1: per-axis distances and the first round of the hash.
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cz;
  logic [HASH_BITS-1:0]  hx;
  logic [HASH_BITS-1:0]  hz;
  logic [D_BITS-1:0]     dx1;
  logic [D_BITS-1:0]     dz1;
  logic [HASH_BITS-1:0]  h1;

  assign cx = query.cell_x[COORD_BITS-1:0];
  assign cz = query.cell_z[COORD_BITS-1:0];
  assign hx = HASH_BITS'(cx) * HASH_C1;
  assign hz = HASH_BITS'(cz) * HASH_C2;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx1 <= axis_dist(query.goal_x_lo[COORD_BITS-1:0], query.goal_x_hi[COORD_BITS-1:0], cx);
      dz1 <= axis_dist(query.goal_z_lo[COORD_BITS-1:0], query.goal_z_hi[COORD_BITS-1:0], cz);
      h1  <= query.search_id ^ hx ^ hz;
    end
  end

  // Stage 2: major/minor split and the unweighted octile cost in Q16.
  logic [D_BITS-1:0]    major;
  logic [D_BITS-1:0]    minor;
  logic [BASE_BITS-1:0] base2;
  logic [HASH_BITS-1:0] h2;

  assign major = (dz1 <= dx1) ? dx1 : dz1;
  assign minor = (dz1 <= dx1) ? dz1 : dx1;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      base2 <= (BASE_BITS'(major) << 16) + BASE_BITS'(minor) * BASE_BITS'(OCT_K_Q16);
      h2    <= (h1 ^ (h1 >> 16)) * HASH_C3;
    end
  end

  // Stage 3: weight the cost and return it to Q8.
  logic [WPROD_BITS-1:0]  wprod;
  logic [SCALED_BITS-1:0] scaled3;
  logic [HASH_BITS-1:0]   h3;

  assign wprod = WPROD_BITS'(base2) * WPROD_BITS'(weight_q8);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      scaled3 <= wprod[WPROD_BITS-1:16];
      h3      <= (h2 ^ (h2 >> 15)) * HASH_C4;
    end
  end

  // Stage 4: final hash fold down to its low byte, times the spread.
  // A zero spread makes this product, and so the noise, zero.
  logic [7:0]             noise_byte;
  logic [SCALED_BITS-1:0] scaled4;
  logic [NPROD_BITS-1:0]  nprod4;

  assign noise_byte = h3[7:0] ^ h3[23:16];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      scaled4 <= scaled3;
      nprod4  <= NPROD_BITS'(noise_byte) * NPROD_BITS'(spread_q8);
    end
  end

  // Stage 5: divide the noise product by 255 through the reciprocal.
  logic [RPROD_BITS-1:0]  rprod;
  logic [SCALED_BITS-1:0] scaled5;
  logic [SPREAD_BITS-1:0] noise5;

  assign rprod = RPROD_BITS'(nprod4) * RPROD_BITS'(RECIP_255);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      scaled5 <= scaled4;
      noise5  <= rprod[RECIP_SHIFT +: SPREAD_BITS];
    end
  end

  // Stage 6: add the noise, saturate, and hold the answer until taken.
  logic [SUM_BITS-1:0]  sum;
  logic [WIDE_BITS-1:0] sum_wide;
  logic [COST_BITS-1:0] cost6;

  assign sum      = SUM_BITS'(scaled5) + SUM_BITS'(noise5);
  assign sum_wide = WIDE_BITS'(sum);

  always_ff @(posedge clk) begin
    if (rdy6) begin
      cost6 <= (sum_wide > WIDE_BITS'(COST_MAX)) ? COST_MAX : sum_wide[COST_BITS-1:0];
    end
  end

  assign answer.valid   = v6;
  assign answer.cost_q8 = cost6;

endmodule
